// File: rtl/shfr_pkg.sv
// Shared types, codes and constants for the sync-header frame receiver.
`timescale 1ns / 1ps

package shfr_pkg;

  // Header and type byte codes
  localparam logic [7:0] HDR1 = 8'hA1;
  localparam logic [7:0] HDR2 = 8'hB2;
  localparam logic [7:0] HDR3 = 8'hC3;

  localparam int unsigned NUM_TYPES = 4;
  localparam logic [7:0] TYPE_CODES [NUM_TYPES] = '{8'hAA, 8'hBB, 8'hCC, 8'hDD};

  // Configuration register file
  localparam int unsigned LEN_W   = 10;
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_LEN_IMAGE_ROW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEN_FILE_NAME = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LEN_LOCATION  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LEN_COMMAND   = 2'd3;

  localparam logic [LEN_W-1:0] RST_LEN_IMAGE_ROW = 10'd482;
  localparam logic [LEN_W-1:0] RST_LEN_FILE_NAME = 10'd30;
  localparam logic [LEN_W-1:0] RST_LEN_LOCATION  = 10'd30;
  localparam logic [LEN_W-1:0] RST_LEN_COMMAND   = 10'd1;

  localparam int unsigned MAX_PAYLOAD_DEF = 512;

  // Depth of the queue between parser and output stage
  localparam int unsigned QDEPTH = 2;

  // Output field widths
  localparam int unsigned IDX_W = 9;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_GOOD    = 2'd1,
    KIND_BAD     = 2'd2,
    KIND_REJECT  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    PH_HUNT1,
    PH_HUNT2,
    PH_HUNT3,
    PH_TYPE,
    PH_PAYLOAD,
    PH_CHECK
  } phase_e;

  // One result item as it travels through the queue
  typedef struct packed {
    kind_e             kind;
    logic [1:0]        frame_type;
    logic [7:0]        data_byte;
    logic [IDX_W-1:0]  byte_index;
    logic              last_byte;
  } res_t;

endpackage

// File: rtl/shfr_front.sv
// Front end: length registers, header hunt, type decode, payload count and checksum.
`timescale 1ns / 1ps

module shfr_front #(
  parameter int unsigned MAX_PAYLOAD = shfr_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // byte input
  input  logic                           accept_i,
  input  logic [7:0]                     rx_byte_i,
  // configuration writes
  input  logic                           cfg_we_i,
  input  logic [shfr_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [shfr_pkg::LEN_W-1:0]     cfg_data_i,
  // result toward the queue
  output logic                           push_o,
  output shfr_pkg::res_t                 push_data_o
);
  import shfr_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_PAYLOAD);
  localparam int unsigned CMP_W = (CNT_W + 1 > LEN_W) ? CNT_W + 1 : LEN_W;

  phase_e             phase_q, phase_d;
  logic [1:0]         type_q, type_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [7:0]         xor_q, xor_d;
  logic [LEN_W-1:0]   len_q [NUM_TYPES];

  logic               type_found;
  logic [1:0]         type_idx;
  logic [LEN_W-1:0]   len_sel;
  logic [CMP_W-1:0]   eff_len;
  logic [CMP_W-1:0]   next_pos;
  logic               is_last;

  // Length registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q[CFG_LEN_IMAGE_ROW] <= RST_LEN_IMAGE_ROW;
      len_q[CFG_LEN_FILE_NAME] <= RST_LEN_FILE_NAME;
      len_q[CFG_LEN_LOCATION]  <= RST_LEN_LOCATION;
      len_q[CFG_LEN_COMMAND]   <= RST_LEN_COMMAND;
    end else if (cfg_we_i) begin
      len_q[cfg_index_i] <= cfg_data_i;
    end
  end

  // Type byte decode
  always_comb begin
    type_found = 1'b0;
    type_idx   = 2'd0;
    for (int i = 0; i < NUM_TYPES; i++) begin
      if (rx_byte_i == TYPE_CODES[i]) begin
        type_found = 1'b1;
        type_idx   = 2'(i);
      end
    end
  end

  // Effective length, clamped to 1..MAX_PAYLOAD; read again at every byte
  always_comb begin
    len_sel = len_q[type_q];
    if (len_sel == '0) begin
      eff_len = CMP_W'(1);
    end else if (CMP_W'(len_sel) > CMP_W'(MAX_PAYLOAD)) begin
      eff_len = CMP_W'(MAX_PAYLOAD);
    end else begin
      eff_len = CMP_W'(len_sel);
    end
    next_pos = CMP_W'(count_q) + CMP_W'(1);
    is_last  = (next_pos >= eff_len);
  end

  // Next state
  always_comb begin
    phase_d = phase_q;
    type_d  = type_q;
    count_d = count_q;
    xor_d   = xor_q;
    if (accept_i) begin
      unique case (phase_q)
        PH_HUNT1: begin
          if (rx_byte_i == HDR1) phase_d = PH_HUNT2;
        end
        PH_HUNT2: begin
          phase_d = (rx_byte_i == HDR2) ? PH_HUNT3 : PH_HUNT1;
        end
        PH_HUNT3: begin
          phase_d = (rx_byte_i == HDR3) ? PH_TYPE : PH_HUNT1;
        end
        PH_TYPE: begin
          if (type_found) begin
            type_d  = type_idx;
            xor_d   = rx_byte_i;
            count_d = '0;
            phase_d = PH_PAYLOAD;
          end else begin
            phase_d = PH_HUNT1;
            type_d  = '0;
            count_d = '0;
            xor_d   = '0;
          end
        end
        PH_PAYLOAD: begin
          xor_d = xor_q ^ rx_byte_i;
          if (is_last) begin
            count_d = '0;
            phase_d = PH_CHECK;
          end else begin
            count_d = count_q + CNT_W'(1);
          end
        end
        PH_CHECK: begin
          phase_d = PH_HUNT1;
          type_d  = '0;
          count_d = '0;
          xor_d   = '0;
        end
        default: begin
          phase_d = PH_HUNT1;
          type_d  = '0;
          count_d = '0;
          xor_d   = '0;
        end
      endcase
    end
  end

  // Result item for the current byte
  always_comb begin
    push_o                 = 1'b0;
    push_data_o.kind       = KIND_PAYLOAD;
    push_data_o.frame_type = type_q;
    push_data_o.data_byte  = rx_byte_i;
    push_data_o.byte_index = '0;
    push_data_o.last_byte  = 1'b0;
    unique case (phase_q)
      PH_TYPE: begin
        push_o                 = accept_i && !type_found;
        push_data_o.kind       = KIND_REJECT;
        push_data_o.frame_type = '0;
      end
      PH_PAYLOAD: begin
        push_o                 = accept_i;
        push_data_o.byte_index = IDX_W'(count_q);
        push_data_o.last_byte  = is_last;
      end
      PH_CHECK: begin
        push_o           = accept_i;
        push_data_o.kind = (rx_byte_i == xor_q) ? KIND_GOOD : KIND_BAD;
      end
      default: begin
        push_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT1;
      type_q  <= '0;
      count_q <= '0;
      xor_q   <= '0;
    end else begin
      phase_q <= phase_d;
      type_q  <= type_d;
      count_q <= count_d;
      xor_q   <= xor_d;
    end
  end

endmodule

// File: rtl/shfr_queue.sv
// Short result queue between the parser and the output stage.
`timescale 1ns / 1ps

module shfr_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  shfr_pkg::res_t push_data_i,
  output logic           full_o,
  output logic           valid_o,
  output shfr_pkg::res_t data_o,
  input  logic           pop_i
);
  import shfr_pkg::*;

  localparam int unsigned PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QDEPTH + 1);

  res_t             mem_q [QDEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CNT_W'(QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

// File: rtl/shfr_back.sv
// Back end: output register that drains the queue toward the result channel.
`timescale 1ns / 1ps

module shfr_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  input  shfr_pkg::res_t q_data_i,
  output logic           q_pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output shfr_pkg::res_t out_data_o
);
  import shfr_pkg::*;

  logic out_valid_q, out_valid_d;
  res_t out_data_q;
  logic load;

  // Reload when the register is empty or its item is being taken
  assign load        = !out_valid_q || out_ready_i;
  assign q_pop_o     = q_valid_i && load;
  assign out_valid_d = load ? q_valid_i : out_valid_q;

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      out_data_q <= q_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// File: rtl/sync_header_frame_receiver.sv
// Sync-header frame receiver with XOR checksum: top level.
// Takes one received byte per clock cycle while input ready is high and gives at most
// one result per byte. The parser writes each result into a two-entry queue and the
// output register takes it from the queue whenever that register is empty or its item
// is being taken. Input ready drops only while that queue is full, so with the result
// side taking every cycle one byte per cycle flows through indefinitely. Length
// registers (payload bytes per frame type) are written through the cfg port, which
// is always ready; lengths of 0 act as 1 and lengths above MAX_PAYLOAD act as
// MAX_PAYLOAD.
`timescale 1ns / 1ps

module sync_header_frame_receiver #(
  parameter int unsigned MAX_PAYLOAD = shfr_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // byte input channel
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [7:0]                     rx_byte_i,
  // result channel
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [1:0]                     kind_o,
  output logic [1:0]                     frame_type_o,
  output logic [7:0]                     data_byte_o,
  output logic [shfr_pkg::IDX_W-1:0]     byte_index_o,
  output logic                           last_byte_o,
  // configuration write channel
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [shfr_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [shfr_pkg::LEN_W-1:0]     cfg_data_i
);
  import shfr_pkg::*;

  logic accept;
  logic push;
  res_t push_data;
  logic q_full;
  logic q_valid;
  res_t q_data;
  logic q_pop;
  res_t out_data;

  assign in_ready_o  = !q_full;
  assign accept      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  // Parser
  shfr_front #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .rx_byte_i   (rx_byte_i),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .push_o      (push),
    .push_data_o (push_data)
  );

  // Result queue
  shfr_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .valid_o     (q_valid),
    .data_o      (q_data),
    .pop_i       (q_pop)
  );

  // Output register
  shfr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (q_data),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data)
  );

  assign kind_o       = out_data.kind;
  assign frame_type_o = out_data.frame_type;
  assign data_byte_o  = out_data.data_byte;
  assign byte_index_o = out_data.byte_index;
  assign last_byte_o  = out_data.last_byte;

endmodule

// File: sim/shfr_frame_checker.sv
// Result checker for the sync-header frame receiver: byte-level predictor and compare.
`timescale 1ns / 1ps

module shfr_frame_checker
  import shfr_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // byte channel
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  logic [7:0]           rx_byte_i,
  // result channel
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  logic [1:0]           kind_i,
  input  logic [1:0]           frame_type_i,
  input  logic [7:0]           data_byte_i,
  input  logic [IDX_W-1:0]     byte_index_i,
  input  logic                 last_byte_i,
  // length register writes
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [LEN_W-1:0]     cfg_data_i,
  // status for the testbench top
  output int                   mismatches_o,
  output int                   pending_o,
  output int                   payload_seen_o,
  output int                   good_seen_o,
  output int                   bad_seen_o,
  output int                   reject_seen_o
);

  // Shadow of the receiver state
  phase_e           phase;
  logic [1:0]       cur_type;
  logic [9:0]       payload_pos;
  logic [7:0]       running_sum;
  logic [LEN_W-1:0] frame_len_q [NUM_TYPES];

  res_t frame_results_q [$];
  res_t head;
  int   mismatches;
  int   n_payload;
  int   n_good;
  int   n_bad;
  int   n_reject;

  // Effective payload length: 0 acts as 1, anything past the max is clamped
  function automatic int payload_length(input logic [1:0] t);
    int n;
    n = frame_len_q[t];
    if (n == 0) n = 1;
    if (n > MAX_PAYLOAD) n = MAX_PAYLOAD;
    return n;
  endfunction

  task automatic restart_hunt();
    phase       = PH_HUNT1;
    cur_type    = 2'd0;
    payload_pos = '0;
    running_sum = '0;
  endtask

  task automatic flag(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("MISMATCH at %0t ns: %s", $time, msg);
  endtask

  // Advance the shadow state by one received byte, queueing any result it causes
  task automatic deframe_byte(input logic [7:0] b);
    int   idx;
    bit   hit;
    res_t r;
    r = '0;
    case (phase)
      PH_HUNT1: if (b == HDR1) phase = PH_HUNT2;
      PH_HUNT2: phase = (b == HDR2) ? PH_HUNT3 : PH_HUNT1;
      PH_HUNT3: phase = (b == HDR3) ? PH_TYPE : PH_HUNT1;
      PH_TYPE: begin
        hit = 1'b0;
        for (int t = 0; t < NUM_TYPES; t++) begin
          if (!hit && b == TYPE_CODES[t]) begin
            cur_type = 2'(t);
            hit      = 1'b1;
          end
        end
        if (hit) begin
          running_sum = b;
          payload_pos = '0;
          phase       = PH_PAYLOAD;
        end else begin
          r.kind      = KIND_REJECT;
          r.data_byte = b;
          frame_results_q.push_back(r);
          n_reject++;
          restart_hunt();
        end
      end
      PH_PAYLOAD: begin
        idx          = payload_pos;
        running_sum ^= b;
        r.kind       = KIND_PAYLOAD;
        r.frame_type = cur_type;
        r.data_byte  = b;
        r.byte_index = IDX_W'(idx);
        r.last_byte  = (idx + 1 >= payload_length(cur_type));
        frame_results_q.push_back(r);
        n_payload++;
        if (r.last_byte) begin
          payload_pos = '0;
          phase       = PH_CHECK;
        end else begin
          payload_pos = 10'(idx + 1);
        end
      end
      PH_CHECK: begin
        if (b == running_sum) begin
          r.kind = KIND_GOOD;
          n_good++;
        end else begin
          r.kind = KIND_BAD;
          n_bad++;
        end
        r.frame_type = cur_type;
        r.data_byte  = b;
        frame_results_q.push_back(r);
        restart_hunt();
      end
      default: restart_hunt();
    endcase
  endtask

  // Compare first: a result leaving now belongs to an earlier byte
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_len_q[CFG_LEN_IMAGE_ROW] = RST_LEN_IMAGE_ROW;
      frame_len_q[CFG_LEN_FILE_NAME] = RST_LEN_FILE_NAME;
      frame_len_q[CFG_LEN_LOCATION]  = RST_LEN_LOCATION;
      frame_len_q[CFG_LEN_COMMAND]   = RST_LEN_COMMAND;
      restart_hunt();
      frame_results_q.delete();
      mismatches = 0;
      n_payload  = 0;
      n_good     = 0;
      n_bad      = 0;
      n_reject   = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (frame_results_q.size() == 0) begin
          flag($sformatf("unexpected item kind %0d type %0d data %02h index %0d last %0d",
                         kind_i, frame_type_i, data_byte_i, byte_index_i, last_byte_i));
        end else begin
          head = frame_results_q.pop_front();
          if (kind_i !== head.kind || frame_type_i !== head.frame_type ||
              data_byte_i !== head.data_byte || byte_index_i !== head.byte_index ||
              last_byte_i !== head.last_byte) begin
            flag($sformatf({"expected kind %0d type %0d data %02h index %0d last %0d, ",
                            "got kind %0d type %0d data %02h index %0d last %0d"},
                           head.kind, head.frame_type, head.data_byte, head.byte_index,
                           head.last_byte, kind_i, frame_type_i, data_byte_i,
                           byte_index_i, last_byte_i));
          end
        end
      end
      if (in_valid_i && in_ready_i) deframe_byte(rx_byte_i);
      if (cfg_valid_i && cfg_ready_i) frame_len_q[cfg_index_i] = cfg_data_i;
    end
    mismatches_o   <= mismatches;
    pending_o      <= frame_results_q.size();
    payload_seen_o <= n_payload;
    good_seen_o    <= n_good;
    bad_seen_o     <= n_bad;
    reject_seen_o  <= n_reject;
  end

endmodule

// File: sim/tb_sync_header_frame_receiver.sv
// Testbench top for the sync-header frame receiver: stimulus, stalls and verdict.
`timescale 1ns / 1ps

module tb_sync_header_frame_receiver;
  import shfr_pkg::*;

  localparam int MAXLEN = MAX_PAYLOAD_DEF;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic [7:0]           rx_byte_i   = '0;
  logic                 out_ready_i = 1'b1;
  logic                 cfg_valid_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = CFG_LEN_IMAGE_ROW;
  logic [LEN_W-1:0]     cfg_data_i  = '0;

  logic                 in_ready_o;
  logic                 out_valid_o;
  logic [1:0]           kind_o;
  logic [1:0]           frame_type_o;
  logic [7:0]           data_byte_o;
  logic [IDX_W-1:0]     byte_index_o;
  logic                 last_byte_o;
  logic                 cfg_ready_o;

  int mismatches;
  int pending;
  int n_payload;
  int n_good;
  int n_bad;
  int n_reject;

  bit quiet       = 1'b0;
  int stall_left  = 0;
  int frame_bytes = 0;
  int n_settings  = 0;
  int eff_len [NUM_TYPES];

  always #5 clk_i = ~clk_i;

  sync_header_frame_receiver u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .rx_byte_i   (rx_byte_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .kind_o      (kind_o),
    .frame_type_o(frame_type_o),
    .data_byte_o (data_byte_o),
    .byte_index_o(byte_index_o),
    .last_byte_o (last_byte_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  shfr_frame_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .rx_byte_i     (rx_byte_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .kind_i        (kind_o),
    .frame_type_i  (frame_type_o),
    .data_byte_i   (data_byte_o),
    .byte_index_i  (byte_index_o),
    .last_byte_i   (last_byte_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .mismatches_o  (mismatches),
    .pending_o     (pending),
    .payload_seen_o(n_payload),
    .good_seen_o   (n_good),
    .bad_seen_o    (n_bad),
    .reject_seen_o (n_reject)
  );

  // Result-side back-pressure in bursts
  initial begin
    forever begin
      @(posedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        if (stall_left == 0) out_ready_i <= 1'b1;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        out_ready_i <= 1'b0;
        stall_left = $urandom_range(1, 18);
      end
    end
  end

  // One byte through the input handshake, sometimes after a gap
  task automatic put_byte(input logic [7:0] b);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // Wait for every expected item to leave, then let the pipeline settle
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_len(input logic [CFG_IDX_W-1:0] idx, input logic [LEN_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    eff_len[idx] = (val == 0) ? 1 : (val > MAXLEN) ? MAXLEN : int'(val);
    @(posedge clk_i);
  endtask

  task automatic write_all(input int aa, input int bb, input int cc, input int dd);
    write_len(CFG_LEN_IMAGE_ROW, LEN_W'(aa));
    write_len(CFG_LEN_FILE_NAME, LEN_W'(bb));
    write_len(CFG_LEN_LOCATION, LEN_W'(cc));
    write_len(CFG_LEN_COMMAND, LEN_W'(dd));
    n_settings++;
  endtask

  // Mostly short lengths, now and then zero or a longer one
  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 0;
    if (r == 1) return $urandom_range(9, 40);
    return $urandom_range(1, 8);
  endfunction

  // Complete frame with random payload; corrupt flips the checksum
  task automatic send_frame(input int t, input bit corrupt);
    logic [7:0] sum;
    logic [7:0] b;
    put_byte(HDR1);
    put_byte(HDR2);
    put_byte(HDR3);
    put_byte(TYPE_CODES[t]);
    sum = TYPE_CODES[t];
    for (int i = 0; i < eff_len[t]; i++) begin
      b = 8'($urandom);
      put_byte(b);
      sum ^= b;
    end
    put_byte(corrupt ? (sum ^ 8'($urandom_range(1, 255))) : sum);
    frame_bytes += eff_len[t] + 5;
  endtask

  // Noise, then a frame (now and then with a bad checksum), a broken header or an unknown type
  task automatic random_sequence();
    int         pick;
    logic [7:0] b;
    repeat ($urandom_range(0, 2)) begin
      b = 8'($urandom);
      if (b == HDR1) b = 8'h00;
      put_byte(b);
    end
    pick = $urandom_range(0, 19);
    if (pick < 16) begin
      send_frame($urandom_range(0, 3), $urandom_range(0, 3) == 0);
    end else if (pick < 18) begin
      // header cut after one or two bytes
      put_byte(HDR1);
      if (pick == 17) put_byte(HDR2);
      b = 8'($urandom);
      if ((pick == 16 && b == HDR2) || (pick == 17 && b == HDR3)) b = 8'h00;
      put_byte(b);
    end else begin
      put_byte(HDR1);
      put_byte(HDR2);
      put_byte(HDR3);
      b = 8'($urandom);
      for (int k = 0; k < NUM_TYPES; k++) begin
        if (b == TYPE_CODES[k]) b = 8'h00;
      end
      put_byte(b);
    end
  endtask

  // Main stimulus
  initial begin
    logic [7:0] opening [$];
    logic [7:0] sum;
    logic [7:0] b;

    eff_len[CFG_LEN_IMAGE_ROW] = RST_LEN_IMAGE_ROW;
    eff_len[CFG_LEN_FILE_NAME] = RST_LEN_FILE_NAME;
    eff_len[CFG_LEN_LOCATION]  = RST_LEN_LOCATION;
    eff_len[CFG_LEN_COMMAND]   = RST_LEN_COMMAND;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset lengths: good command frame, false start on a repeated first header
    // byte, two unknown types, and a command frame with a bad checksum
    opening = '{HDR1, HDR2, HDR3, TYPE_CODES[3], 8'h5A, TYPE_CODES[3] ^ 8'h5A,
                HDR1, HDR1, HDR2, HDR3, TYPE_CODES[3],
                HDR1, HDR2, HDR3, 8'h00,
                HDR1, HDR2, HDR3, 8'hFF,
                HDR1, HDR2, HDR3, TYPE_CODES[3], 8'hFF, 8'h00};
    foreach (opening[i]) put_byte(opening[i]);
    drain();

    // Every type once, zero length on the image row, then a file-name frame with a bad checksum
    write_all(0, 1, 2, 3);
    for (int t = 0; t < NUM_TYPES; t++) send_frame(t, 1'b0);
    send_frame(1, 1'b1);
    drain();

    // Shorten the file-name length while a frame is half received
    write_len(CFG_LEN_FILE_NAME, 10'd6);
    put_byte(HDR1);
    put_byte(HDR2);
    put_byte(HDR3);
    put_byte(TYPE_CODES[1]);
    sum = TYPE_CODES[1];
    repeat (4) begin
      b = 8'($urandom);
      put_byte(b);
      sum ^= b;
    end
    drain();
    write_len(CFG_LEN_FILE_NAME, 10'd2);
    b = 8'($urandom);
    put_byte(b);
    put_byte(sum ^ b);
    drain();

    // Longest frames: exact maximum and a clamped all-ones length
    write_all(MAXLEN, 5, 1023, 0);
    send_frame(0, 1'b0);
    send_frame(2, 1'b1);
    send_frame(3, 1'b0);
    drain();

    // Random settings, each followed by a batch of mixed traffic
    frame_bytes = 0;
    while (frame_bytes < 60) begin
      write_all(pick_len(), pick_len(), pick_len(), pick_len());
      repeat (8) random_sequence();
      drain();
    end

    // Closing batch with both sides always ready
    quiet = 1'b1;
    write_all(pick_len(), pick_len(), pick_len(), pick_len());
    repeat (8) random_sequence();
    drain();

    $display("Covered %0d payload bytes, %0d good frames, %0d bad checksums, %0d bad types",
             n_payload, n_good, n_bad, n_reject);
    $display("across %0d length settings incl. 0, 512, 1023 and a mid-frame cut", n_settings);
    if (mismatches == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// File: sim.f
rtl/shfr_pkg.sv
rtl/shfr_front.sv
rtl/shfr_queue.sv
rtl/shfr_back.sv
rtl/sync_header_frame_receiver.sv
sim/shfr_frame_checker.sv
sim/tb_sync_header_frame_receiver.sv
